// ----- hw/rtl/fpqu_pkg.sv -----
package fpqu_pkg;

	localparam int FRAC_BITS = 14;
	localparam int COS_SHIFT = 3;
	localparam int SIN_SHIFT = 1;

	typedef logic signed [15:0] word_t;
	typedef logic [1:0] opcode_t;

	localparam word_t ONE_VALUE = 16'sd16384;

	localparam opcode_t OP_MUL   = 2'd0;
	localparam opcode_t OP_ROT   = 2'd1;
	localparam opcode_t OP_EULER = 2'd2;

	typedef word_t quat_t [4];
	typedef word_t terms_t [16];

	// Product term: full 16x16 product, arithmetic shift, low 16 bits.
	// Component sums wrap to 16 bits, so each term may be cut to 16 bits.
	function automatic word_t mul_term(input word_t a, input word_t b);
		logic signed [31:0] p;
		p = 32'(a) * 32'(b);
		return p[FRAC_BITS+15:FRAC_BITS];
	endfunction

	// Small-angle cosine: one minus the scaled square, wrapped.
	function automatic word_t cos_approx(input word_t a);
		logic signed [31:0] p;
		logic signed [31:0] sh;
		p  = 32'(a) * 32'(a);
		sh = p >>> (FRAC_BITS + COS_SHIFT);
		return ONE_VALUE - sh[15:0];
	endfunction

	// Hamilton product from the 16 terms m[4*i+j] = p_i * q_j.
	function automatic quat_t ham_sum(input terms_t m);
		quat_t r;
		r[0] = m[0]  - m[5]  - m[10] - m[15];
		r[1] = m[4]  + m[1]  + m[11] - m[14];
		r[2] = m[2]  - m[7]  + m[8]  + m[13];
		r[3] = m[3]  + m[6]  - m[9]  + m[12];
		return r;
	endfunction

endpackage

// ----- hw/rtl/fixed_point_quaternion_unit.sv -----
// Channel  Handshake             Payload
// -------  --------------------  ------------------------------------------------
// in       in_valid / in_stall   opcode, left_w..left_z, right_w..right_z,
//                                angle_x..angle_z
// out      out_valid / out_stall out_w, out_x, out_y, out_z
//
// Five register stages, s1 to s5, lie between input and output.
// One beat per cycle is accepted while in_stall is low; the multiplier stages
// (s1, s3, s4) each hold one row of 16x16 multipliers.
// Reset clears only the stage valid bits; payload registers are not reset.
// Stalls back up stage by stage; a stage with no valid beat always loads,
// so bubbles are squeezed out while out_stall is high.
module fixed_point_quaternion_unit (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  fpqu_pkg::opcode_t       opcode,
	input  fpqu_pkg::word_t         left_w,
	input  fpqu_pkg::word_t         left_x,
	input  fpqu_pkg::word_t         left_y,
	input  fpqu_pkg::word_t         left_z,
	input  fpqu_pkg::word_t         right_w,
	input  fpqu_pkg::word_t         right_x,
	input  fpqu_pkg::word_t         right_y,
	input  fpqu_pkg::word_t         right_z,
	input  fpqu_pkg::word_t         angle_x,
	input  fpqu_pkg::word_t         angle_y,
	input  fpqu_pkg::word_t         angle_z,

	output logic                    out_valid,
	input  logic                    out_stall,
	output fpqu_pkg::word_t         out_w,
	output fpqu_pkg::word_t         out_x,
	output fpqu_pkg::word_t         out_y,
	output fpqu_pkg::word_t         out_z
);

	// ---------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor loads.
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || !out_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------------
	// s1: left x right term products; cosines and sines of the angles.
	// cs order: (y, z, x), matching c1, c2, c3 / s1, s2, s3.
	// ---------------------------------------------------------------------
	fpqu_pkg::quat_t   lq, rq;
	fpqu_pkg::word_t   ang [3];
	fpqu_pkg::terms_t  m1;
	fpqu_pkg::word_t   c1w [3];
	fpqu_pkg::word_t   s1w [3];

	fpqu_pkg::opcode_t op_s1;
	fpqu_pkg::terms_t  m_s1;
	fpqu_pkg::quat_t   l_s1;
	fpqu_pkg::word_t   c_s1 [3];
	fpqu_pkg::word_t   sn_s1 [3];

	always_comb begin
		lq[0] = left_w;  lq[1] = left_x;  lq[2] = left_y;  lq[3] = left_z;
		rq[0] = right_w; rq[1] = right_x; rq[2] = right_y; rq[3] = right_z;
		ang[0] = angle_y;
		ang[1] = angle_z;
		ang[2] = angle_x;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				m1[4*i+j] = fpqu_pkg::mul_term(lq[i], rq[j]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			c1w[k] = fpqu_pkg::cos_approx(ang[k]);
			s1w[k] = ang[k] >>> fpqu_pkg::SIN_SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1 <= opcode;
			m_s1  <= m1;
			l_s1  <= lq;
			c_s1  <= c1w;
			sn_s1 <= s1w;
		end
	end

	// ---------------------------------------------------------------------
	// s2: first Hamilton sum (final for multiply, intermediate for rotate).
	// ---------------------------------------------------------------------
	fpqu_pkg::opcode_t op_s2;
	fpqu_pkg::quat_t   tmp_s2;
	fpqu_pkg::quat_t   l_s2;
	fpqu_pkg::word_t   c_s2 [3];
	fpqu_pkg::word_t   sn_s2 [3];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2  <= op_s1;
			tmp_s2 <= fpqu_pkg::ham_sum(m_s1);
			l_s2   <= l_s1;
			c_s2   <= c_s1;
			sn_s2  <= sn_s1;
		end
	end

	// ---------------------------------------------------------------------
	// s3: shared multiplier row. Rotate: tmp x conj(left), 16 terms.
	// Euler: the seven inner products c1c2, s1s2, s2c3, c2c3, c1s2,
	// c1c3, c2s3 in slots 0..6. Negation of -32768 wraps to itself.
	// ---------------------------------------------------------------------
	fpqu_pkg::word_t   a3 [16];
	fpqu_pkg::word_t   b3 [16];
	fpqu_pkg::quat_t   cj;
	fpqu_pkg::terms_t  m3;

	fpqu_pkg::opcode_t op_s3;
	fpqu_pkg::terms_t  m_s3;
	fpqu_pkg::quat_t   res_s3;
	fpqu_pkg::word_t   c3_s3;
	fpqu_pkg::word_t   sn_s3 [3];

	always_comb begin
		cj[0] = l_s2[0];
		for (int i = 1; i < 4; i++) begin
			cj[i] = -l_s2[i];
		end
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				a3[4*i+j] = tmp_s2[i];
				b3[4*i+j] = cj[j];
			end
		end
		if (op_s2 == fpqu_pkg::OP_EULER) begin
			a3[0] = c_s2[0];  b3[0] = c_s2[1];
			a3[1] = sn_s2[0]; b3[1] = sn_s2[1];
			a3[2] = sn_s2[1]; b3[2] = c_s2[2];
			a3[3] = c_s2[1];  b3[3] = c_s2[2];
			a3[4] = c_s2[0];  b3[4] = sn_s2[1];
			a3[5] = c_s2[0];  b3[5] = c_s2[2];
			a3[6] = c_s2[1];  b3[6] = sn_s2[2];
		end
		for (int k = 0; k < 16; k++) begin
			m3[k] = fpqu_pkg::mul_term(a3[k], b3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3  <= op_s2;
			m_s3   <= m3;
			res_s3 <= tmp_s2;
			c3_s3  <= c_s2[2];
			sn_s3  <= sn_s2;
		end
	end

	// ---------------------------------------------------------------------
	// s4: rotate finishes its second Hamilton sum; Euler forms its eight
	// outer products.
	// ---------------------------------------------------------------------
	fpqu_pkg::word_t   e4 [8];

	fpqu_pkg::opcode_t op_s4;
	fpqu_pkg::quat_t   res_s4;
	fpqu_pkg::word_t   e_s4 [8];

	always_comb begin
		e4[0] = fpqu_pkg::mul_term(m_s3[0], c3_s3);     // c12 * c3
		e4[1] = fpqu_pkg::mul_term(m_s3[1], sn_s3[2]);  // s1s2 * s3
		e4[2] = fpqu_pkg::mul_term(sn_s3[0], m_s3[2]);  // s1 * s2c3
		e4[3] = fpqu_pkg::mul_term(m_s3[0], sn_s3[2]);  // c12 * s3
		e4[4] = fpqu_pkg::mul_term(sn_s3[0], m_s3[3]);  // s1 * c2c3
		e4[5] = fpqu_pkg::mul_term(m_s3[4], sn_s3[2]);  // c1s2 * s3
		e4[6] = fpqu_pkg::mul_term(sn_s3[1], m_s3[5]);  // s2 * c1c3
		e4[7] = fpqu_pkg::mul_term(sn_s3[0], m_s3[6]);  // s1 * c2s3
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			op_s4 <= op_s3;
			e_s4  <= e4;
			if (op_s3 == fpqu_pkg::OP_ROT) begin
				res_s4 <= fpqu_pkg::ham_sum(m_s3);
			end else begin
				res_s4 <= res_s3;
			end
		end
	end

	// ---------------------------------------------------------------------
	// s5: output register. Unused opcode gives all zeros.
	// ---------------------------------------------------------------------
	fpqu_pkg::quat_t   res5;
	fpqu_pkg::quat_t   out_s5;

	always_comb begin
		unique case (op_s4)
			fpqu_pkg::OP_MUL,
			fpqu_pkg::OP_ROT: begin
				res5 = res_s4;
			end
			fpqu_pkg::OP_EULER: begin
				res5[0] = e_s4[0] - e_s4[1];
				res5[1] = e_s4[2] + e_s4[3];
				res5[2] = e_s4[4] + e_s4[5];
				res5[3] = e_s4[6] - e_s4[7];
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					res5[i] = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			out_s5 <= res5;
		end
	end

	assign out_valid = v_s5;
	assign out_w     = out_s5[0];
	assign out_x     = out_s5[1];
	assign out_y     = out_s5[2];
	assign out_z     = out_s5[3];

endmodule
